/* rtl/core/hss_pkg.sv */
// ----------------------------------------------------------------------------
// HMM sequence sampler package
// Shared types and constants for the sampler's front end, queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

package hss_pkg;

   // Field widths. The probability format is fixed by the item fields:
   // PROB_BITS fractional bits, and one extra bit so that 1.0 itself fits.
   localparam int PROB_BITS    = 16;
   localparam int PROB_W       = PROB_BITS + 1;
   localparam int RANDOM_W     = PROB_BITS;
   localparam int OPCODE_W     = 2;
   localparam int INDEX_W      = 4;
   localparam int SIU_W        = 5;
   localparam int SYMBOL_W     = 2;
   localparam int MODEL_STATE_W = 4;

   localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << PROB_BITS;

   // Defaults for the top-level parameters.
   localparam int DEF_MAX_STATES    = 16;
   localparam int DEF_ALPHABET_SIZE = 4;
   localparam int DEF_QUEUE_DEPTH   = 4;

   // Reserved model states and the reset value of the state count register.
   localparam int START_STATE         = 0;
   localparam int END_STATE           = 1;
   localparam int STATES_IN_USE_RESET = 4;

   typedef enum logic [OPCODE_W-1:0] {
      OP_STEP       = 2'd0,
      OP_LOAD_TRANS = 2'd1,
      OP_LOAD_EMIT  = 2'd2
   } hss_opcode_type;

   // One classified item as it travels through the queue.
   typedef struct packed {
      hss_opcode_type        opcode;
      logic [INDEX_W-1:0]    row;
      logic [INDEX_W-1:0]    col;
      logic [PROB_W-1:0]     prob;
      logic [RANDOM_W-1:0]   r_trans;
      logic [RANDOM_W-1:0]   r_emit;
   } hss_item_type;

   // Head of the queue as seen by the back end.
   typedef struct packed {
      logic         valid;
      hss_item_type item;
   } hss_head_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_TRANS,
      BK_EMIT,
      BK_RESULT
   } hss_back_state_type;

endpackage : hss_pkg

`default_nettype wire

/* rtl/core/hmm_sequence_sampler.sv */
// ----------------------------------------------------------------------------
// HMM sequence sampler
// Draws symbol sequences from a hidden Markov model by inverse-CDF selection.
// ----------------------------------------------------------------------------
// Load items write raw transition and emission probabilities (unsigned
// fractions, 65536 is 1.0; larger values are stored as 1.0). A step item
// carries two uniform random fractions: the block walks the current state's
// transition row over the first states_in_use entries, entering the first
// state whose saturating running sum is not below the first value (the state
// stays if none is), then walks that state's emission row with the second
// value and returns the matching symbol. Entering the end state returns an
// end-of-sequence item and the next step starts from the start state; a step
// whose emission walk matches nothing returns no item. Items are taken into a
// four-entry queue, so the request side keeps moving while the back end works
// until the queue fills. The back end handles one item at a time: a step
// walks T transition entries, where T is at most the state count (16 by
// default), and then E emission entries, at most the alphabet size (4), and
// its result may then wait on rsp_stall. Each walk reads one table entry per
// cycle from its RAM, and that single read port sets the step time.
// Table contents are undefined after reset; a step may read only written
// entries. The user must write states_in_use through the csr port only while
// no item is in flight; the block itself does not enforce it. It resets to 4.
// ----------------------------------------------------------------------------
`default_nettype none

module hmm_sequence_sampler
   import hss_pkg::*;
#(
   parameter int MAX_STATES    = DEF_MAX_STATES,
   parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE,
   parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // Request items.
   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire logic [OPCODE_W-1:0]      req_opcode,
   input  wire logic [INDEX_W-1:0]       req_row_state,
   input  wire logic [INDEX_W-1:0]       req_column_index,
   input  wire logic [PROB_W-1:0]        req_probability,
   input  wire logic [RANDOM_W-1:0]      req_random_transition,
   input  wire logic [RANDOM_W-1:0]      req_random_emission,
   // Result items.
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      logic [SYMBOL_W-1:0]      rsp_symbol,
   output      logic                     rsp_end_of_sequence,
   output      logic [MODEL_STATE_W-1:0] rsp_model_state,
   // Configuration write.
   input  wire logic                     csr_valid,
   output      logic                     csr_ready,
   input  wire logic [SIU_W-1:0]         csr_states_in_use
);

   logic [SIU_W-1:0] states_in_use_ff, states_in_use_in;
   logic             queue_full;
   logic             push;
   logic             pop;
   hss_item_type     push_item;
   hss_head_type     head;

   // The register can always be written.
   assign csr_ready = 1'b1;

   always_comb begin
      states_in_use_in = states_in_use_ff;
      if (csr_valid && csr_ready) begin
         states_in_use_in = csr_states_in_use;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         states_in_use_ff <= SIU_W'(STATES_IN_USE_RESET);
      end else begin
         states_in_use_ff <= states_in_use_in;
      end
   end

   // Front end: accept and classify; unknown opcodes and loads outside the
   // tables are dropped here and never reach the queue.
   hss_front #(
      .MAX_STATES    (MAX_STATES),
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_front (
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_opcode            (req_opcode),
      .req_row_state         (req_row_state),
      .req_column_index      (req_column_index),
      .req_probability       (req_probability),
      .req_random_transition (req_random_transition),
      .req_random_emission   (req_random_emission),
      .queue_full            (queue_full),
      .push                  (push),
      .push_item             (push_item)
   );

   hss_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .head      (head)
   );

   // Back end: owns both probability tables, the current state and the
   // result register.
   hss_back #(
      .MAX_STATES    (MAX_STATES),
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .states_in_use       (states_in_use_ff),
      .head                (head),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_symbol          (rsp_symbol),
      .rsp_end_of_sequence (rsp_end_of_sequence),
      .rsp_model_state     (rsp_model_state)
   );

endmodule : hmm_sequence_sampler

`default_nettype wire

/* rtl/core/hss_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module hss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : hss_ram

`default_nettype wire

/* rtl/core/hss_front.sv */
// ----------------------------------------------------------------------------
// HMM sampler front end
// Accepts request items, drops the ones that do nothing and queues the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module hss_front
   import hss_pkg::*;
#(
   parameter int MAX_STATES    = DEF_MAX_STATES,
   parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE
) (
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic [OPCODE_W-1:0] req_opcode,
   input  wire logic [INDEX_W-1:0]  req_row_state,
   input  wire logic [INDEX_W-1:0]  req_column_index,
   input  wire logic [PROB_W-1:0]   req_probability,
   input  wire logic [RANDOM_W-1:0] req_random_transition,
   input  wire logic [RANDOM_W-1:0] req_random_emission,
   input  wire logic                queue_full,
   output      logic                push,
   output      hss_item_type        push_item
);

   logic keep;

   assign req_stall = queue_full;

   always_comb begin
      keep = 1'b0;
      unique case (req_opcode)
         OP_STEP: begin
            keep = 1'b1;
         end
         OP_LOAD_TRANS: begin
            keep = (32'(req_row_state) < MAX_STATES) &&
                   (32'(req_column_index) < MAX_STATES);
         end
         OP_LOAD_EMIT: begin
            keep = (32'(req_row_state) < MAX_STATES) &&
                   (32'(req_column_index) < ALPHABET_SIZE);
         end
         default: begin
            keep = 1'b0;
         end
      endcase

      push_item.opcode  = hss_opcode_type'(req_opcode);
      push_item.row     = req_row_state;
      push_item.col     = req_column_index;
      // Probabilities above 1.0 are stored as 1.0.
      push_item.prob    = (req_probability > PROB_ONE) ? PROB_ONE : req_probability;
      push_item.r_trans = req_random_transition;
      push_item.r_emit  = req_random_emission;
   end

   assign push = req_valid && !queue_full && keep;

endmodule : hss_front

`default_nettype wire

/* rtl/core/hss_queue.sv */
// ----------------------------------------------------------------------------
// HMM sampler item queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hss_queue
   import hss_pkg::*;
#(
   parameter int DEPTH = DEF_QUEUE_DEPTH
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire hss_item_type push_item,
   output      logic         full,
   input  wire logic         pop,
   output      hss_head_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   hss_item_type     entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.item  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("queue read while empty");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue holds more items than its depth");
`endif

endmodule : hss_queue

`default_nettype wire

/* rtl/core/hss_back.sv */
// ----------------------------------------------------------------------------
// HMM sampler back end
// Carries out queued items: table writes, and the transition and emission
// row walks of a step, with the result held in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hss_back
   import hss_pkg::*;
#(
   parameter int MAX_STATES    = DEF_MAX_STATES,
   parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [SIU_W-1:0]         states_in_use,
   input  wire hss_head_type             head,
   output      logic                     pop,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      logic [SYMBOL_W-1:0]      rsp_symbol,
   output      logic                     rsp_end_of_sequence,
   output      logic [MODEL_STATE_W-1:0] rsp_model_state
);

   localparam int MAXC     = (MAX_STATES > ALPHABET_SIZE) ? MAX_STATES : ALPHABET_SIZE;
   localparam int IDX_W    = $clog2(MAXC);
   localparam int CNT_W    = $clog2(MAXC + 1);
   localparam int SW       = $clog2(MAX_STATES);
   localparam int TR_DEPTH = MAX_STATES * MAX_STATES;
   localparam int EM_DEPTH = MAX_STATES * ALPHABET_SIZE;
   localparam int TAW      = $clog2(TR_DEPTH);
   localparam int EAW      = $clog2(EM_DEPTH);

   hss_back_state_type       st_ff, st_in;
   logic [SW-1:0]            cur_state_ff, cur_state_in;
   logic [IDX_W-1:0]         walk_idx_ff, walk_idx_in;
   logic [CNT_W-1:0]         n_ff, n_in;
   logic [PROB_W-1:0]        sum_ff, sum_in;
   logic [RANDOM_W-1:0]      r_trans_ff, r_trans_in;
   logic [RANDOM_W-1:0]      r_emit_ff, r_emit_in;
   logic [SYMBOL_W-1:0]      res_symbol_ff, res_symbol_in;
   logic                     res_eos_ff, res_eos_in;
   logic [MODEL_STATE_W-1:0] res_state_ff, res_state_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [SYMBOL_W-1:0]      rsp_symbol_ff, rsp_symbol_in;
   logic                     rsp_eos_ff, rsp_eos_in;
   logic [MODEL_STATE_W-1:0] rsp_state_ff, rsp_state_in;

   logic              tr_we, tr_re, em_we, em_re;
   logic [TAW-1:0]    tr_waddr, tr_raddr;
   logic [EAW-1:0]    em_waddr, em_raddr;
   logic [PROB_W-1:0] tr_rdata, em_rdata;

   logic              begin_em;
   logic [SW-1:0]     em_state;
   logic [PROB_W-1:0] row_data;
   logic [PROB_W:0]   sum_raw;
   logic [PROB_W-1:0] sum_next;
   logic              hit;
   logic [SW+3:0]     state_wide;

   hss_ram #(.WIDTH(PROB_W), .DEPTH(TR_DEPTH)) u_trans_ram (
      .clock   (clock),
      .wr_en   (tr_we),
      .wr_addr (tr_waddr),
      .wr_data (head.item.prob),
      .rd_en   (tr_re),
      .rd_addr (tr_raddr),
      .rd_data (tr_rdata)
   );

   hss_ram #(.WIDTH(PROB_W), .DEPTH(EM_DEPTH)) u_emit_ram (
      .clock   (clock),
      .wr_en   (em_we),
      .wr_addr (em_waddr),
      .wr_data (head.item.prob),
      .rd_en   (em_re),
      .rd_addr (em_raddr),
      .rd_data (em_rdata)
   );

   // Running sum that saturates at 1.0, and the match against the random value.
   always_comb begin
      row_data = (st_ff == BK_EMIT) ? em_rdata : tr_rdata;
      sum_raw  = {1'b0, sum_ff} + {1'b0, row_data};
      sum_next = (sum_raw > {1'b0, PROB_ONE}) ? PROB_ONE : sum_raw[PROB_W-1:0];
      if (st_ff == BK_EMIT) begin
         hit = PROB_W'(r_emit_ff) <= sum_next;
      end else begin
         hit = PROB_W'(r_trans_ff) <= sum_next;
      end
   end

   always_comb begin
      st_in         = st_ff;
      cur_state_in  = cur_state_ff;
      walk_idx_in   = walk_idx_ff;
      n_in          = n_ff;
      sum_in        = sum_ff;
      r_trans_in    = r_trans_ff;
      r_emit_in     = r_emit_ff;
      res_symbol_in = res_symbol_ff;
      res_eos_in    = res_eos_ff;
      res_state_in  = res_state_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_eos_in    = rsp_eos_ff;
      rsp_state_in  = rsp_state_ff;
      pop           = 1'b0;
      tr_we         = 1'b0;
      em_we         = 1'b0;
      tr_re         = 1'b0;
      em_re         = 1'b0;
      tr_waddr      = TAW'(int'(head.item.row) * MAX_STATES + int'(head.item.col));
      em_waddr      = EAW'(int'(head.item.row) * ALPHABET_SIZE + int'(head.item.col));
      tr_raddr      = '0;
      em_raddr      = '0;
      begin_em      = 1'b0;
      em_state      = cur_state_ff;
      state_wide    = (SW + 4)'(cur_state_ff);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (st_ff)
         BK_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               case (head.item.opcode)
                  OP_LOAD_TRANS: begin
                     tr_we = 1'b1;
                  end
                  OP_LOAD_EMIT: begin
                     em_we = 1'b1;
                  end
                  default: begin
                     r_trans_in = head.item.r_trans;
                     r_emit_in  = head.item.r_emit;
                     if (32'(states_in_use) > MAX_STATES) begin
                        n_in = CNT_W'(MAX_STATES);
                     end else begin
                        n_in = CNT_W'(states_in_use);
                     end
                     if (n_in == '0) begin
                        begin_em = 1'b1;
                     end else begin
                        tr_re       = 1'b1;
                        tr_raddr    = TAW'(int'(cur_state_ff) * MAX_STATES);
                        walk_idx_in = '0;
                        sum_in      = '0;
                        st_in       = BK_TRANS;
                     end
                  end
               endcase
            end
         end

         BK_TRANS: begin
            if (hit) begin
               begin_em = 1'b1;
               em_state = walk_idx_ff[SW-1:0];
            end else if ((CNT_W'(walk_idx_ff) + CNT_W'(1)) == n_ff) begin
               begin_em = 1'b1;
            end else begin
               sum_in      = sum_next;
               walk_idx_in = walk_idx_ff + IDX_W'(1);
               tr_re       = 1'b1;
               tr_raddr    = TAW'(int'(cur_state_ff) * MAX_STATES + int'(walk_idx_ff) + 1);
            end
         end

         BK_EMIT: begin
            if (hit) begin
               res_symbol_in = walk_idx_ff[SYMBOL_W-1:0];
               res_eos_in    = 1'b0;
               res_state_in  = state_wide[MODEL_STATE_W-1:0];
               st_in         = BK_RESULT;
            end else if (walk_idx_ff == IDX_W'(ALPHABET_SIZE - 1)) begin
               // No symbol matched: the step ends without a result.
               st_in = BK_IDLE;
            end else begin
               sum_in      = sum_next;
               walk_idx_in = walk_idx_ff + IDX_W'(1);
               em_re       = 1'b1;
               em_raddr    = EAW'(int'(cur_state_ff) * ALPHABET_SIZE + int'(walk_idx_ff) + 1);
            end
         end

         BK_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_symbol_in = res_symbol_ff;
               rsp_eos_in    = res_eos_ff;
               rsp_state_in  = res_state_ff;
               st_in         = BK_IDLE;
            end
         end

         default: begin
            st_in = BK_IDLE;
         end
      endcase

      // The transition walk is over: enter the chosen state and either report
      // the end of the sequence or start the emission walk.
      if (begin_em) begin
         if (em_state == SW'(END_STATE)) begin
            cur_state_in  = SW'(START_STATE);
            res_symbol_in = '0;
            res_eos_in    = 1'b1;
            res_state_in  = MODEL_STATE_W'(END_STATE);
            st_in         = BK_RESULT;
         end else begin
            cur_state_in = em_state;
            em_re        = 1'b1;
            em_raddr     = EAW'(int'(em_state) * ALPHABET_SIZE);
            walk_idx_in  = '0;
            sum_in       = '0;
            st_in        = BK_EMIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= BK_IDLE;
         cur_state_ff <= SW'(START_STATE);
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         cur_state_ff <= cur_state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_idx_ff   <= walk_idx_in;
      n_ff          <= n_in;
      sum_ff        <= sum_in;
      r_trans_ff    <= r_trans_in;
      r_emit_ff     <= r_emit_in;
      res_symbol_ff <= res_symbol_in;
      res_eos_ff    <= res_eos_in;
      res_state_ff  <= res_state_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_eos_ff    <= rsp_eos_in;
      rsp_state_ff  <= rsp_state_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_symbol          = rsp_symbol_ff;
   assign rsp_end_of_sequence = rsp_eos_ff;
   assign rsp_model_state     = rsp_state_ff;

`ifndef SYNTHESIS
   a_walk_in_row: assert property (@(posedge clock) disable iff (reset)
      (st_ff == BK_TRANS) |-> (CNT_W'(walk_idx_ff) < n_ff))
      else $error("transition walk ran past the states in use");

   a_end_result_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_eos_ff) |->
         (rsp_symbol_ff == '0) && (rsp_state_ff == MODEL_STATE_W'(END_STATE)))
      else $error("end of sequence result carries a symbol or wrong state");

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      (st_ff == BK_RESULT && res_eos_ff) |-> (cur_state_ff == SW'(START_STATE)))
      else $error("end state reached but walk does not restart at the start state");
`endif

endmodule : hss_back

`default_nettype wire
